// File: design/sesstab_pkg.sv
// Shared types, constants and helpers for the session table with ID allocator.
// Used by sesstab_cmp, the top level session_table_with_id_allocator and sesstab_chk.
// No dependencies.
package sesstab_pkg;

  // Command codes carried on s_tuser
  localparam logic [1:0] CMD_INSERT     = 2'd0;
  localparam logic [1:0] CMD_DELETE     = 2'd1;
  localparam logic [1:0] CMD_LOOKUP_KEY = 2'd2;
  localparam logic [1:0] CMD_LOOKUP_ID  = 2'd3;

  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int HANDLE_W = 16;
  localparam int ID_W     = 31;
  localparam int COUNT_W  = 7;

  // Largest identifier; allocation wraps from here back to 1
  localparam logic [ID_W-1:0] ID_LIMIT = 31'd2000000000;

  // Payload widths on the stream ports
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 56;

  // One table slot as held in memory
  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   address;
    logic [PORT_W-1:0]   port;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Per-slot compare results from the shared compare unit
  typedef struct packed {
    logic key_match;
    logic id_match;
    logic is_free;
    logic id_greater;
  } cmp_flags_t;

  // Successor of an identifier, wrapping past the limit to 1
  function automatic logic [ID_W-1:0] next_id(input logic [ID_W-1:0] v);
    logic [ID_W-1:0] r;
    if (v >= ID_LIMIT) begin
      r = {{(ID_W-1){1'b0}}, 1'b1};
    end else begin
      r = v + {{(ID_W-1){1'b0}}, 1'b1};
    end
    return r;
  endfunction

endpackage

// File: design/sesstab_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; no package dependencies.
module sesstab_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register the read word every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/sesstab_cmp.sv
// Shared slot compare unit: key match, ID match, free slot and running maximum.
// Depends on sesstab_pkg for slot_t and cmp_flags_t.
module sesstab_cmp (
  input  sesstab_pkg::slot_t                    slot,
  input  logic [sesstab_pkg::ADDR_W-1:0]        key_address,
  input  logic [sesstab_pkg::PORT_W-1:0]        key_port,
  input  logic [sesstab_pkg::ID_W-1:0]          target_id,
  input  logic [sesstab_pkg::ID_W-1:0]          max_id,
  output sesstab_pkg::cmp_flags_t               flags
);

  // Compare one slot word against the current search terms
  always_comb begin
    flags.key_match  = slot.valid && (slot.address == key_address) && (slot.port == key_port);
    flags.id_match   = slot.valid && (slot.id == target_id);
    flags.is_free    = !slot.valid;
    flags.id_greater = slot.valid && (slot.id > max_id);
  end

endmodule

// File: design/session_table_with_id_allocator.sv
// Session table keyed by IPv4 address and port, with identifier allocation.
// Depends on sesstab_pkg, sesstab_ram and sesstab_cmp.
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+---------------------------------------------
//  s_*     | in  | s_tvalid, s_tready | s_tuser: command; s_tdata: key, handle, ID
//  m_*     | out | m_tvalid, m_tready | m_tdata: success, ID, handle, entry count
//
// Every command sweeps the slot memory at least once through the shared compare unit,
// one slot a cycle; an insert sweeps again for each identifier in use that it skips,
// and a delete sweeps once more to find the new largest identifier in use.
// After reset a clearing pass marks all slots free; s_tready stays low.
// One transaction is in work at a time; a finished result waits in the output
// register while the next transaction is accepted and processed.
module session_table_with_id_allocator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] peer_address, [47:32] peer_port, [63:48] session_handle,
  // [94:64] lookup_id, [95] zero
  input  logic [sesstab_pkg::IN_DATA_W-1:0] s_tdata,
  // [1:0] command
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] success, [31:1] entry_id, [47:32] entry_handle, [54:48] entry_count,
  // [55] zero
  output logic [sesstab_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SWEEP  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_WRITE  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  localparam logic [1:0] MODE_FIND  = 2'd0;
  localparam logic [1:0] MODE_IDCHK = 2'd1;
  localparam logic [1:0] MODE_MAX   = 2'd2;

  logic [2:0] state;
  logic [1:0] mode;

  // Transaction registers
  logic [1:0]                         cmd;
  logic [sesstab_pkg::ADDR_W-1:0]     key_address;
  logic [sesstab_pkg::PORT_W-1:0]     key_port;
  logic [sesstab_pkg::HANDLE_W-1:0]   new_handle;
  logic [sesstab_pkg::ID_W-1:0]       target_id;

  // Sweep control
  logic [AW-1:0] idx;
  logic          iss_active;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;

  // Sweep results
  logic                               key_hit;
  logic [AW-1:0]                      key_slot;
  logic [sesstab_pkg::ID_W-1:0]       key_id;
  logic [sesstab_pkg::HANDLE_W-1:0]   key_handle;
  logic                               id_hit;
  logic [sesstab_pkg::HANDLE_W-1:0]   id_handle;
  logic                               free_found;
  logic [AW-1:0]                      free_slot;
  logic [sesstab_pkg::ID_W-1:0]       max_id;

  // Table state
  logic [CW-1:0]                      valid_count;
  logic [sesstab_pkg::ID_W-1:0]       last_id;

  // Pending write and result
  logic [AW-1:0]                      wr_slot;
  sesstab_pkg::slot_t                 wr_word;
  logic                               res_ok;
  logic [sesstab_pkg::ID_W-1:0]       res_id;
  logic [sesstab_pkg::HANDLE_W-1:0]   res_handle;

  // Memory port
  logic                               ram_we;
  logic [AW-1:0]                      ram_addr;
  sesstab_pkg::slot_t                 ram_wdata;
  sesstab_pkg::slot_t                 ram_rdata;
  logic [sesstab_pkg::SLOT_W-1:0]     ram_rbits;

  sesstab_pkg::cmp_flags_t            flags;
  logic                               out_free;
  logic                               in_fire;
  logic [CW+6:0]                      count_ext;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign ram_rdata = sesstab_pkg::slot_t'(ram_rbits);
  assign count_ext = {7'd0, valid_count};

  // Select memory address and write data by phase
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx;
    ram_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_addr  = wr_slot;
        ram_wdata = wr_word;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sesstab_ram #(
    .WIDTH (sesstab_pkg::SLOT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rbits)
  );

  sesstab_cmp u_cmp (
    .slot        (ram_rdata),
    .key_address (key_address),
    .key_port    (key_port),
    .target_id   (target_id),
    .max_id      (max_id),
    .flags       (flags)
  );

  // Sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      mode        <= MODE_FIND;
      idx         <= '0;
      iss_active  <= 1'b0;
      rd_vld      <= 1'b0;
      valid_count <= '0;
      last_id     <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      rd_vld <= iss_active;

      // Drop the result once taken; a new load below overrides
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          idx <= idx + AW'(1);
          if (idx == LAST_SLOT) begin
            idx   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            mode       <= MODE_FIND;
            idx        <= '0;
            iss_active <= 1'b1;
            state      <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (iss_active) begin
            idx <= idx + AW'(1);
            if (idx == LAST_SLOT) begin
              iss_active <= 1'b0;
            end
          end
          if (rd_vld && rd_idx == LAST_SLOT) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state <= ST_DONE;
          if (cmd == sesstab_pkg::CMD_INSERT) begin
            if (!(mode == MODE_FIND && (key_hit || !free_found))) begin
              if (id_hit) begin
                mode       <= MODE_IDCHK;
                idx        <= '0;
                iss_active <= 1'b1;
                state      <= ST_SWEEP;
              end else begin
                state <= ST_WRITE;
              end
            end
          end else if (cmd == sesstab_pkg::CMD_DELETE) begin
            if (mode == MODE_FIND && key_hit) begin
              state <= ST_WRITE;
            end else if (mode == MODE_MAX) begin
              last_id <= max_id;
            end
          end
        end
        ST_WRITE: begin
          if (cmd == sesstab_pkg::CMD_INSERT) begin
            last_id     <= target_id;
            valid_count <= valid_count + CW'(1);
            state       <= ST_DONE;
          end else begin
            valid_count <= valid_count - CW'(1);
            mode        <= MODE_MAX;
            idx         <= '0;
            iss_active  <= 1'b1;
            state       <= ST_SWEEP;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Sweep accumulators, transaction payload and result registers
  always_ff @(posedge clk) begin
    rd_idx <= idx;

    // Latch the command and pick the ID to search for
    if (in_fire) begin
      cmd         <= s_tuser;
      key_address <= s_tdata[31:0];
      key_port    <= s_tdata[47:32];
      new_handle  <= s_tdata[63:48];
      if (s_tuser == sesstab_pkg::CMD_LOOKUP_ID) begin
        target_id <= s_tdata[94:64];
      end else begin
        target_id <= sesstab_pkg::next_id(last_id);
      end
    end

    // Clear flags at the start of each sweep
    if (in_fire || (state == ST_DECIDE) || (state == ST_WRITE)) begin
      key_hit    <= 1'b0;
      id_hit     <= 1'b0;
      free_found <= 1'b0;
      max_id     <= '0;
    end else if (rd_vld && state == ST_SWEEP) begin
      if (flags.key_match && !key_hit) begin
        key_hit    <= 1'b1;
        key_slot   <= rd_idx;
        key_id     <= ram_rdata.id;
        key_handle <= ram_rdata.handle;
      end
      if (flags.id_match && !id_hit) begin
        id_hit    <= 1'b1;
        id_handle <= ram_rdata.handle;
      end
      if (flags.is_free && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= rd_idx;
      end
      if (flags.id_greater) begin
        max_id <= ram_rdata.id;
      end
    end

    // Decide the outcome and stage the memory write
    if (state == ST_DECIDE) begin
      res_ok     <= 1'b0;
      res_id     <= '0;
      res_handle <= '0;
      unique case (cmd)
        sesstab_pkg::CMD_INSERT: begin
          if (id_hit) begin
            target_id <= sesstab_pkg::next_id(target_id);
          end
          wr_slot         <= free_slot;
          wr_word.valid   <= 1'b1;
          wr_word.address <= key_address;
          wr_word.port    <= key_port;
          wr_word.id      <= target_id;
          wr_word.handle  <= new_handle;
        end
        sesstab_pkg::CMD_DELETE: begin
          wr_slot <= key_slot;
          wr_word <= '0;
          if (mode == MODE_MAX) begin
            res_ok <= 1'b1;
            res_id <= key_id;
          end
        end
        sesstab_pkg::CMD_LOOKUP_KEY: begin
          if (key_hit) begin
            res_ok     <= 1'b1;
            res_id     <= key_id;
            res_handle <= key_handle;
          end
        end
        sesstab_pkg::CMD_LOOKUP_ID: begin
          if (id_hit) begin
            res_ok     <= 1'b1;
            res_id     <= target_id;
            res_handle <= id_handle;
          end
        end
        default: begin
          res_ok <= 1'b0;
        end
      endcase
    end

    // Report the allocated ID on a completed insert
    if (state == ST_WRITE && cmd == sesstab_pkg::CMD_INSERT) begin
      res_ok     <= 1'b1;
      res_id     <= target_id;
      res_handle <= '0;
    end

    // Load the output register
    if (state == ST_DONE && out_free) begin
      m_tdata <= {1'b0, count_ext[6:0], res_handle, res_id, res_ok};
    end
  end

endmodule

// File: design/sesstab_chk.sv
// Port-level checker for session_table_with_id_allocator, bound to the top level.
// Depends on sesstab_pkg for the identifier limit.
module sesstab_chk #(
  parameter int TABLE_DEPTH = 64
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [sesstab_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic [1:0]                         s_tuser,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [sesstab_pkg::OUT_DATA_W-1:0] m_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transaction changed while stalled");

  // Failed results carry no ID and no handle
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[47:1] == 47'd0)
    else $error("failed result carries nonzero ID or handle");

  // Successful results carry an ID in range
  a_id_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[31:1] != 31'd0 && m_tdata[31:1] <= sesstab_pkg::ID_LIMIT)
    else $error("successful result carries ID out of range");

  // Take one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a transaction is in work");

  // Hold input off during the clearing pass
  a_clear_busy: assert property (@(posedge clk)
    $fell(rst) |-> !s_tready)
    else $error("input ready during clearing pass");

endmodule

bind session_table_with_id_allocator sesstab_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_sesstab_chk (.*);
